// ----- rtl/core/lrc_pkg.sv -----
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants of the canvas rasterizer
// Command codes, controller states, and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package lrc_pkg;

   localparam int CANVAS_WIDTH_DEF  = 64;
   localparam int CANVAS_HEIGHT_DEF = 64;
   localparam int ROW_BITS          = 64;   // one word per canvas row
   localparam int COORD_W           = 11;   // signed plot coordinates
   localparam int DIST_W            = 9;    // line span magnitudes
   localparam int REQ_W             = 48;
   localparam int RSP_W             = 72;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_LINE   = 3'd1,
      OP_RECT   = 3'd2,
      OP_CIRCLE = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_WIPE,    // clearing pass after reset
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_SEG,     // set up one line segment
      ST_LPT,     // form the next line point
      ST_PRD,     // plot: read the row
      ST_PWR,     // plot: write the row back
      ST_LADV,
      ST_CSET,
      ST_CPT,     // form one of the eight circle points
      ST_CADV,
      ST_CSQ,     // walk the rounded square root down
      ST_ROW,
      ST_RCAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic clr_write;
      logic seg_setup;
      logic seg_next;
      logic lpt;
      logic ladv;
      logic circ_setup;
      logic circ_pt;
      logic circ_padv;
      logic circ_step;
      logic circ_dec;
      logic plot_rd;
      logic plot_wr;
      logic row_rd;
      logic row_cap;
      logic finish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   clr_last;
      logic   in_range;
      logic   line_last;
      logic   seg_last;
      logic   pt_last;
      logic   sq_dec;
      logic   circ_cont;
      logic   out_free;
   } status_type;

endpackage

// ----- rtl/core/lrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrc_ctrl: command sequencer
// Steps through clear sweeps, line and rectangle walks, the circle walk and
// row reads, issuing one datapath command group per cycle.
// ----------------------------------------------------------------------------
module lrc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lrc_pkg::status_type status,
   output lrc_pkg::cmd_type    cmd
);
   import lrc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_WIPE: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_CLEAR:          state_in = ST_CLEAR;
               OP_LINE, OP_RECT:  state_in = ST_SEG;
               OP_CIRCLE:         state_in = ST_CSET;
               OP_READ:           state_in = ST_ROW;
               default:           state_in = ST_DONE;
            endcase
         end
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SEG: begin
            cmd.seg_setup = 1'b1;
            state_in      = ST_LPT;
         end
         ST_LPT: begin
            cmd.lpt  = 1'b1;
            state_in = ST_PRD;
         end
         ST_PRD: begin
            cmd.plot_rd = 1'b1;
            if (status.in_range) begin
               state_in = ST_PWR;
            end else if (status.op == OP_CIRCLE) begin
               state_in = ST_CADV;
            end else begin
               state_in = ST_LADV;
            end
         end
         ST_PWR: begin
            cmd.plot_wr = 1'b1;
            state_in    = (status.op == OP_CIRCLE) ? ST_CADV : ST_LADV;
         end
         ST_LADV: begin
            if (!status.line_last) begin
               cmd.ladv = 1'b1;
               state_in = ST_LPT;
            end else if (status.op == OP_RECT && !status.seg_last) begin
               cmd.seg_next = 1'b1;
               state_in     = ST_SEG;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CSET: begin
            cmd.circ_setup = 1'b1;
            state_in       = ST_CPT;
         end
         ST_CPT: begin
            cmd.circ_pt = 1'b1;
            state_in    = ST_PRD;
         end
         ST_CADV: begin
            if (!status.pt_last) begin
               cmd.circ_padv = 1'b1;
               state_in      = ST_CPT;
            end else begin
               cmd.circ_step = 1'b1;
               state_in      = ST_CSQ;
            end
         end
         ST_CSQ: begin
            if (status.sq_dec) begin
               cmd.circ_dec = 1'b1;
            end else if (status.circ_cont) begin
               state_in = ST_CPT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROW: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_RCAP;
         end
         ST_RCAP: begin
            cmd.row_cap = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/lrc_dpath.sv -----
// ----------------------------------------------------------------------------
// lrc_dpath: canvas memory and drawing arithmetic
// Holds the canvas rows, the line stepper, the circle square-root walker,
// the plot read-modify-write path and the result register.
// ----------------------------------------------------------------------------
module lrc_dpath #(
   parameter int CANVAS_WIDTH  = lrc_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = lrc_pkg::CANVAS_HEIGHT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lrc_pkg::REQ_W-1:0]  req_tdata,
   input  lrc_pkg::cmd_type           cmd,
   output lrc_pkg::status_type        status,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [lrc_pkg::RSP_W-1:0]  rsp_tdata
);
   import lrc_pkg::*;

   localparam int RW = $clog2(CANVAS_HEIGHT);
   localparam logic signed [COORD_W-1:0] W_LIM = COORD_W'(CANVAS_WIDTH);
   localparam logic signed [COORD_W-1:0] H_LIM = COORD_W'(CANVAS_HEIGHT);

   // latched command
   op_type            op_ff;
   logic signed [7:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic [6:0]        rad_ff;
   logic [5:0]        row_ff;

   // line stepper
   logic signed [COORD_W-1:0] lx0_ff, ly0_ff;
   logic [DIST_W-1:0]         adx_ff, ady_ff, n_ff, i_ff, qx_ff, qy_ff, remx_ff, remy_ff;
   logic                      sx_ff, sy_ff;
   logic [1:0]                seg_ff;

   // circle walker
   logic [6:0]         s_ff;
   logic [7:0]         dy_ff;
   logic signed [15:0] v_ff;
   logic [2:0]         pt_ff;

   // plot point, clear sweep, result
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [RW-1:0]             clr_cnt_ff;
   logic                      clip_ff;
   logic [ROW_BITS-1:0]       result_ff;
   logic                      rsp_valid_ff;
   logic [ROW_BITS-1:0]       rsp_bits_ff;
   logic                      rsp_clip_ff;

   // canvas memory
   logic [ROW_BITS-1:0] canvas_mem [CANVAS_HEIGHT];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [RW-1:0]       rd_addr, wr_addr;
   logic [ROW_BITS-1:0] wr_data, pix_mask;
   logic                wr_en;

   logic signed [COORD_W-1:0] xa_e, ya_e, xb_e, yb_e, xe, ye;
   logic signed [COORD_W-1:0] x0, y0, x1, y1, dxs, dys, adx_w, ady_w;
   logic signed [COORD_W-1:0] qx_e, qy_e, ca, cb, cx_e, cy_e;
   logic [DIST_W:0]           sumx, sumy;
   logic [13:0]               sq, sqm, rsq;
   logic                      in_range, row_ok;
   logic [8:0]                row_ext;

   assign xa_e = {{(COORD_W-8){xa_ff[7]}}, xa_ff};
   assign ya_e = {{(COORD_W-8){ya_ff[7]}}, ya_ff};
   assign xb_e = {{(COORD_W-8){xb_ff[7]}}, xb_ff};
   assign yb_e = {{(COORD_W-8){yb_ff[7]}}, yb_ff};
   assign xe   = xa_e + xb_e;
   assign ye   = ya_e + yb_e;

   // segment end points: a line is one segment, a rectangle four
   always_comb begin
      x0 = xa_e; y0 = ya_e; x1 = xb_e; y1 = yb_e;
      if (op_ff != OP_LINE) begin
         case (seg_ff)
            2'd0:    begin x0 = xa_e; y0 = ya_e; x1 = xe;   y1 = ya_e; end
            2'd1:    begin x0 = xe;   y0 = ya_e; x1 = xe;   y1 = ye;   end
            2'd2:    begin x0 = xe;   y0 = ye;   x1 = xa_e; y1 = ye;   end
            default: begin x0 = xa_e; y0 = ye;   x1 = xa_e; y1 = ya_e; end
         endcase
      end
   end

   assign dxs   = x1 - x0;
   assign dys   = y1 - y0;
   assign adx_w = dxs[COORD_W-1] ? -dxs : dxs;
   assign ady_w = dys[COORD_W-1] ? -dys : dys;
   assign sumx  = {1'b0, remx_ff} + {1'b0, adx_ff};
   assign sumy  = {1'b0, remy_ff} + {1'b0, ady_ff};
   assign qx_e  = COORD_W'(qx_ff);
   assign qy_e  = COORD_W'(qy_ff);

   // circle: eighth-turn swap and the two mirrors come from the point index
   assign ca   = pt_ff[2] ? COORD_W'(dy_ff) : COORD_W'(s_ff);
   assign cb   = pt_ff[2] ? COORD_W'(s_ff)  : COORD_W'(dy_ff);
   assign cx_e = xa_e;
   assign cy_e = ya_e;
   assign sq   = s_ff * s_ff;
   assign sqm  = sq - 14'(s_ff);
   assign rsq  = rad_ff * rad_ff;

   assign in_range = (px_ff >= 0) && (px_ff < W_LIM) && (py_ff >= 0) && (py_ff < H_LIM);
   assign row_ext  = {3'b000, row_ff};
   assign row_ok   = row_ext < 9'(CANVAS_HEIGHT);
   assign pix_mask = {1'b1, {(ROW_BITS-1){1'b0}}} >> px_ff[5:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_tdata[2:0]);
         xa_ff  <= req_tdata[10:3];
         ya_ff  <= req_tdata[18:11];
         xb_ff  <= req_tdata[26:19];
         yb_ff  <= req_tdata[34:27];
         rad_ff <= req_tdata[41:35];
         row_ff <= req_tdata[47:42];
         seg_ff <= 2'd0;
      end else if (cmd.seg_next) begin
         seg_ff <= seg_ff + 2'd1;
      end

      if (cmd.seg_setup) begin
         lx0_ff  <= x0;
         ly0_ff  <= y0;
         adx_ff  <= adx_w[DIST_W-1:0];
         ady_ff  <= ady_w[DIST_W-1:0];
         sx_ff   <= dxs[COORD_W-1];
         sy_ff   <= dys[COORD_W-1];
         n_ff    <= (adx_w > ady_w) ? adx_w[DIST_W-1:0] : ady_w[DIST_W-1:0];
         i_ff    <= '0;
         qx_ff   <= '0;
         qy_ff   <= '0;
         remx_ff <= '0;
         remy_ff <= '0;
      end else if (cmd.ladv) begin
         // carry the remainder of i*|d|/n one step at a time
         i_ff <= i_ff + 1'b1;
         if (sumx >= {1'b0, n_ff}) begin
            remx_ff <= DIST_W'(sumx - {1'b0, n_ff});
            qx_ff   <= qx_ff + 1'b1;
         end else begin
            remx_ff <= sumx[DIST_W-1:0];
         end
         if (sumy >= {1'b0, n_ff}) begin
            remy_ff <= DIST_W'(sumy - {1'b0, n_ff});
            qy_ff   <= qy_ff + 1'b1;
         end else begin
            remy_ff <= sumy[DIST_W-1:0];
         end
      end

      if (cmd.circ_setup) begin
         s_ff  <= rad_ff;
         dy_ff <= '0;
         v_ff  <= $signed({2'b00, rsq});
         pt_ff <= '0;
      end else begin
         if (cmd.circ_padv) begin
            pt_ff <= pt_ff + 3'd1;
         end
         if (cmd.circ_step) begin
            dy_ff <= dy_ff + 8'd1;
            v_ff  <= v_ff - $signed(16'({dy_ff, 1'b1}));
            pt_ff <= '0;
         end
         if (cmd.circ_dec) begin
            s_ff <= s_ff - 7'd1;
         end
      end

      if (cmd.lpt) begin
         px_ff <= lx0_ff + (sx_ff ? -qx_e : qx_e);
         py_ff <= ly0_ff + (sy_ff ? -qy_e : qy_e);
      end else if (cmd.circ_pt) begin
         px_ff <= pt_ff[1] ? cx_e - ca : cx_e + ca;
         py_ff <= pt_ff[0] ? cy_e - cb : cy_e + cb;
      end

      if (cmd.row_cap) begin
         result_ff <= row_ok ? rd_data_ff : '0;
      end else if (cmd.accept) begin
         result_ff <= '0;
      end

      if (cmd.finish) begin
         rsp_bits_ff <= result_ff;
         rsp_clip_ff <= clip_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            clr_cnt_ff <= '0;
            clip_ff    <= 1'b0;
         end else begin
            if (cmd.clr_write) begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
            if (cmd.plot_rd && !in_range) begin
               clip_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // canvas memory: one write and one registered read a cycle
   assign wr_en   = cmd.clr_write | cmd.plot_wr;
   assign wr_addr = cmd.clr_write ? clr_cnt_ff : py_ff[RW-1:0];
   assign wr_data = cmd.clr_write ? '0 : (rd_data_ff | pix_mask);
   assign rd_addr = cmd.row_rd ? row_ext[RW-1:0] : py_ff[RW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         canvas_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= canvas_mem[rd_addr];
   end

   always_comb begin
      status.op        = op_ff;
      status.clr_last  = (clr_cnt_ff == RW'(CANVAS_HEIGHT - 1));
      status.in_range  = in_range;
      status.line_last = (i_ff == n_ff);
      status.seg_last  = (seg_ff == 2'd3);
      status.pt_last   = (pt_ff == 3'd7);
      status.sq_dec    = (s_ff != 7'd0) && ($signed({2'b00, sqm}) >= v_ff);
      status.circ_cont = ({1'b0, s_ff} >= dy_ff);
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-ROW_BITS-1){1'b0}}, rsp_clip_ff, rsp_bits_ff};

endmodule

// ----- rtl/core/line_rect_circle_rasterizer.sv -----
// ----------------------------------------------------------------------------
// line_rect_circle_rasterizer: one-bit-per-pixel canvas rasterizer
// Clears, draws lines, rectangles and circles on a packed canvas, and reads
// canvas rows back.
// ----------------------------------------------------------------------------
// Usage:
//   Each command is one transfer on the req_ channel and returns exactly one
//   transfer on the rsp_ channel: the row bits for a row read (x = 0 in bit 63)
//   and a flag that marks pixels dropped outside the canvas.
//   Commands run one at a time. Every plotted pixel is a read-modify-write of
//   its canvas row through the registered read and the write port, so an
//   on-canvas pixel takes the steps form point, read, write, advance, and a
//   dropped one skips the write. Once the result is loaded into the output
//   register, the sequencer returns to idle before it accepts a new command.
//   After reset the canvas memory is swept to zero, one row a cycle, and
//   req_tready stays low until that sweep is over.
//   The result sits in an output register. A stalled receiver holds it there
//   while the next command is already taken and worked on; that command only
//   waits at its end until the register is free.
// ----------------------------------------------------------------------------
module line_rect_circle_rasterizer #(
   parameter int CANVAS_WIDTH  = lrc_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = lrc_pkg::CANVAS_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // op[2:0], x_a[10:3], y_a[18:11], x_b[26:19], y_b[34:27],
   // radius[41:35], row_index[47:42]
   input  logic [lrc_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // row_bits[63:0], clipped[64], zero fill [71:65]
   output logic [lrc_pkg::RSP_W-1:0] rsp_tdata
);
   import lrc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: decides which datapath operation runs each cycle
   lrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // canvas, stepping arithmetic and output register
   lrc_dpath #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
